@@ rtl/tspd_pkg.sv @@
// ----------------------------------------------------------------------------
// tspd_pkg
// Shared types and constants for the two-station priority dispatch block.
// ----------------------------------------------------------------------------
package tspd_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 10;
   localparam int RANK_W      = ID_W + 1;
   localparam int WAIT_W      = 7;

   typedef enum logic {
      OP_ENQUEUE  = 1'b0,
      OP_DISPATCH = 1'b1
   } opcode_type;

   typedef struct packed {
      logic            pri;
      logic [ID_W-1:0] id;
   } entry_type;

   // Per-cycle command broadcast along a row of cells
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type new_entry;
   } cell_ctrl_type;

   // Larger rank is served earlier: priority first, then lower id
   function automatic logic [RANK_W-1:0] rank_of(entry_type e);
      return {e.pri, ~e.id};
   endfunction

endpackage

@@ rtl/tspd_cell.sv @@
// ----------------------------------------------------------------------------
// tspd_cell
// One slot of a sorted queue: holds an entry, shifts on insert or pop.
// ----------------------------------------------------------------------------
module tspd_cell (
   input  logic                     clock,
   input  tspd_pkg::cell_ctrl_type  ctrl,
   input  logic                     occupied,
   input  tspd_pkg::entry_type      prev_entry,
   input  logic                     prev_goes,
   input  tspd_pkg::entry_type      next_entry,
   output tspd_pkg::entry_type      entry,
   output logic                     goes
);

   tspd_pkg::entry_type entry_ff, entry_in;

   // new entry belongs at or ahead of this slot
   assign goes = !occupied ||
                 (tspd_pkg::rank_of(entry_ff) <= tspd_pkg::rank_of(ctrl.new_entry));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = next_entry;
      end else if (ctrl.insert && goes) begin
         entry_in = prev_goes ? prev_entry : ctrl.new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/tspd_queue.sv @@
// ----------------------------------------------------------------------------
// tspd_queue
// Sorted queue built as a row of cells, head in cell 0, with fill count.
// ----------------------------------------------------------------------------
module tspd_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  tspd_pkg::cell_ctrl_type         ctrl,
   output tspd_pkg::entry_type             head,
   output logic                            full,
   output logic                            empty,
   output logic [tspd_pkg::COUNT_W-1:0]    count,
   output logic [tspd_pkg::COUNT_W-1:0]    count_next
);

   logic [tspd_pkg::COUNT_W-1:0] count_ff, count_in;
   tspd_pkg::entry_type          entries [tspd_pkg::QUEUE_DEPTH];
   logic                         goes    [tspd_pkg::QUEUE_DEPTH];

   genvar i;
   generate
      for (i = 0; i < tspd_pkg::QUEUE_DEPTH; i++) begin : g_cell
         tspd_pkg::entry_type prev_e, next_e;
         logic                prev_g;

         if (i == 0) begin : g_first
            assign prev_e = entries[0];
            assign prev_g = 1'b0;
         end else begin : g_rest
            assign prev_e = entries[i-1];
            assign prev_g = goes[i-1];
         end

         if (i == tspd_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign next_e = entries[i];
         end else begin : g_mid
            assign next_e = entries[i+1];
         end

         tspd_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (tspd_pkg::COUNT_W'(i) < count_ff),
            .prev_entry (prev_e),
            .prev_goes  (prev_g),
            .next_entry (next_e),
            .entry      (entries[i]),
            .goes       (goes[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head       = entries[0];
   assign full       = (count_ff == tspd_pkg::COUNT_W'(tspd_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign count      = count_ff;
   assign count_next = count_in;

endmodule

@@ rtl/two_station_priority_dispatch.sv @@
// ----------------------------------------------------------------------------
// two_station_priority_dispatch
// Two sorted waiting queues (west, east) with enqueue and dispatch commands.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req_ channel: one beat per command. req_tuser is the opcode (enqueue or
//    dispatch); req_tdata carries id, priority and direction for an enqueue.
//  - rsp_ channel: exactly one beat per command, in order, giving the popped
//    entry (if any), a drop flag and both queue fill levels after the command.
//  - Each queue is a row of compare-and-shift cells, head in cell 0. An
//    enqueue makes every cell compare against the new entry, and the cells from
//    the insertion point back shift by one in the same cycle; a dispatch shifts
//    the whole row towards the head. The response beat appears in the cycle
//    after the request beat; one command per cycle unless rsp_tready stalls.
//  - Enqueue into a full queue is dropped and flagged. Dispatch takes west
//    first, east only when west is empty; both empty returns dispatched = 0.
//  - Reset empties both queues (fill counts cleared) and the output register.
//    Cell contents are not cleared; slots above the count are never observed.
//  - Stall: the response register holds while rsp_tready is low, and
//    req_tready drops, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module two_station_priority_dispatch (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] train_id, [10] high_priority,
                                    // [11] heading_west, [15:12] zero
   input  logic        req_tuser,   // [0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [0] dispatched, [10:1] out_id,
                                    // [11] out_priority, [12] out_west,
                                    // [13] enqueue_dropped, [20:14] west_waiting,
                                    // [27:21] east_waiting, [31:28] zero
);

   // ---- request decode ---------------------------------------------------
   logic                   req_beat;
   tspd_pkg::opcode_type   opcode;
   tspd_pkg::entry_type    new_entry;
   logic                   heading_west;

   assign req_beat     = req_tvalid && req_tready;
   assign opcode       = tspd_pkg::opcode_type'(req_tuser);
   assign new_entry.id = req_tdata[tspd_pkg::ID_W-1:0];
   assign new_entry.pri = req_tdata[10];
   assign heading_west = req_tdata[11];

   // ---- queues -----------------------------------------------------------
   tspd_pkg::cell_ctrl_type        west_ctrl, east_ctrl;
   tspd_pkg::entry_type            west_head, east_head;
   logic                           west_full, east_full, west_empty, east_empty;
   logic [tspd_pkg::COUNT_W-1:0]   west_count, east_count;
   logic [tspd_pkg::COUNT_W-1:0]   west_count_next, east_count_next;
   logic                           is_enq, is_disp, enq_drop;

   assign is_enq  = req_beat && (opcode == tspd_pkg::OP_ENQUEUE);
   assign is_disp = req_beat && (opcode == tspd_pkg::OP_DISPATCH);

   // drop when the target queue is already full
   assign enq_drop = is_enq && (heading_west ? west_full : east_full);

   assign west_ctrl.insert    = is_enq && heading_west && !west_full;
   assign west_ctrl.pop       = is_disp && !west_empty;
   assign west_ctrl.new_entry = new_entry;

   // east only serves a dispatch when west has nothing waiting
   assign east_ctrl.insert    = is_enq && !heading_west && !east_full;
   assign east_ctrl.pop       = is_disp && west_empty && !east_empty;
   assign east_ctrl.new_entry = new_entry;

   tspd_queue u_west (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (west_ctrl),
      .head       (west_head),
      .full       (west_full),
      .empty      (west_empty),
      .count      (west_count),
      .count_next (west_count_next)
   );

   tspd_queue u_east (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (east_ctrl),
      .head       (east_head),
      .full       (east_full),
      .empty      (east_empty),
      .count      (east_count),
      .count_next (east_count_next)
   );

   // ---- response assembly ------------------------------------------------
   logic                 dispatched;
   tspd_pkg::entry_type  out_entry;
   logic [31:0]          rsp_data_in, rsp_data_ff;
   logic                 rsp_valid_in, rsp_valid_ff;

   assign dispatched = west_ctrl.pop || east_ctrl.pop;

   always_comb begin
      out_entry = '0;
      if (west_ctrl.pop) begin
         out_entry = west_head;
      end else if (east_ctrl.pop) begin
         out_entry = east_head;
      end
   end

   // fill levels (0 to 64) fit the 7-bit fields without truncation
   assign rsp_data_in = {4'b0000,
                         tspd_pkg::WAIT_W'(east_count_next),
                         tspd_pkg::WAIT_W'(west_count_next),
                         enq_drop,
                         west_ctrl.pop,
                         out_entry.pri,
                         out_entry.id,
                         dispatched};

   // output register parts the two sides; take a beat when it is free or drains
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = req_beat || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- assertions -------------------------------------------------------
   a_west_bound: assert property (@(posedge clock) disable iff (reset)
      west_count <= tspd_pkg::COUNT_W'(tspd_pkg::QUEUE_DEPTH))
      else $error("west fill count above queue depth");

   a_east_bound: assert property (@(posedge clock) disable iff (reset)
      east_count <= tspd_pkg::COUNT_W'(tspd_pkg::QUEUE_DEPTH))
      else $error("east fill count above queue depth");

   a_west_first: assert property (@(posedge clock) disable iff (reset)
      (is_disp && !west_empty) |=> (west_count == $past(west_count) - 1'b1) &&
                                   (east_count == $past(east_count)))
      else $error("dispatch did not serve the west queue first");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[13]))
      else $error("dispatch and drop flagged on the same beat");

endmodule
